/* hw/rtl/obb_separation_margin_defines.svh */
// Assertion macros of the checker file of the separation margin block.
`ifndef OBB_SEPARATION_MARGIN_DEFINES_SVH
`define OBB_SEPARATION_MARGIN_DEFINES_SVH

// Property checked only while reset is released.
`define OBBSM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define OBBSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/obbsm_pkg.sv */
// Shared constants, types and CORDIC helpers of the separation margin block.
package obbsm_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STEPS  = 16;
  localparam int STEPS_PER_STG = 2;
  localparam int CORDIC_STG    = CORDIC_STEPS / STEPS_PER_STG;

  // Stage numbers of the pipeline; stage 0 takes the request.
  localparam int ST_QUAD = CORDIC_STG + 1;
  localparam int SC_STG  = ST_QUAD + 1;
  localparam int ST_PROD = ST_QUAD + 1;
  localparam int ST_ABS  = ST_PROD + 1;
  localparam int ST_SUP  = ST_ABS + 1;
  localparam int ST_GAP  = ST_SUP + 1;
  localparam int ST_MAX  = ST_GAP + 1;
  localparam int ST_OUT  = ST_MAX + 1;
  localparam int NSTG    = ST_OUT + 1;

  localparam int ZW    = 34;
  localparam int GAP_W = 58;

  localparam logic signed [ZW-1:0] CORDIC_X0 = 34'sd652032874;

  localparam logic signed [ZW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    34'sh020000000, 34'sh012E4051E, 34'sh009FB385B, 34'sh0051111D4,
    34'sh0028B0D43, 34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55,
    34'sh00028BE53, 34'sh000145F2F, 34'sh0000A2F98, 34'sh0000517CC,
    34'sh000028BE6, 34'sh0000145F3, 34'sh00000A2FA, 34'sh00000517D
  };

  typedef struct packed {
    logic signed [ZW-1:0] x;
    logic signed [ZW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [15:0] ahl;
    logic [15:0] ahw;
    logic [15:0] bhl;
    logic [15:0] bhw;
  } geo_t;

  function automatic cordic_t cordic_step(input cordic_t a, input logic [3:0] i);
    cordic_t r;
    if (!a.z[ZW-1]) begin
      r.x = a.x - (a.y >>> i);
      r.y = a.y + (a.x >>> i);
      r.z = a.z - ATAN_TURN[i];
    end else begin
      r.x = a.x + (a.y >>> i);
      r.y = a.y - (a.x >>> i);
      r.z = a.z + ATAN_TURN[i];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/obbsm_sincos.sv */
// Pipelined CORDIC sine and cosine of one heading, rounded to Q1.15.
module obbsm_sincos (
  input  logic                           clk,
  input  logic [obbsm_pkg::SC_STG-1:0]   en,
  input  logic [15:0]                    heading,
  output logic signed [15:0]             cos_q15,
  output logic signed [15:0]             sin_q15
);

  obbsm_pkg::cordic_t st_r [obbsm_pkg::CORDIC_STG+1];
  logic [1:0]         q_r  [obbsm_pkg::CORDIC_STG+1];

  logic [31:0] ang;
  logic [1:0]  quad;
  logic [31:0] rem;

  function automatic logic signed [15:0] to_q15(input logic signed [obbsm_pkg::ZW-1:0] v);
    logic signed [obbsm_pkg::ZW-1:0] t;
    t = (v + obbsm_pkg::ZW'(16384)) >>> 15;
    if (t > obbsm_pkg::ZW'(32767)) t = obbsm_pkg::ZW'(32767);
    if (t < -obbsm_pkg::ZW'(32767)) t = -obbsm_pkg::ZW'(32767);
    return t[15:0];
  endfunction

  // Heading bits above the angle width drop off the top of the turn word.
  assign ang  = 32'(heading) << (32 - obbsm_pkg::ANGLE_BITS);
  assign quad = 2'((ang + 32'h2000_0000) >> 30);
  assign rem  = ang - {quad, 30'b0};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q_r[0]    <= quad;
      st_r[0].x <= obbsm_pkg::CORDIC_X0;
      st_r[0].y <= '0;
      st_r[0].z <= {{(obbsm_pkg::ZW-32){rem[31]}}, rem};
    end
  end

  for (genvar g = 1; g <= obbsm_pkg::CORDIC_STG; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en[g]) begin
        q_r[g]  <= q_r[g-1];
        st_r[g] <= obbsm_pkg::cordic_step(
                     obbsm_pkg::cordic_step(st_r[g-1], 4'(2*(g-1))), 4'(2*(g-1)+1));
      end
    end
  end

  logic signed [15:0] xq, yq;
  assign xq = to_q15(st_r[obbsm_pkg::CORDIC_STG].x);
  assign yq = to_q15(st_r[obbsm_pkg::CORDIC_STG].y);

  always_ff @(posedge clk) begin
    if (en[obbsm_pkg::ST_QUAD]) begin
      case (q_r[obbsm_pkg::CORDIC_STG])
        2'd0: begin cos_q15 <= xq;  sin_q15 <= yq;  end
        2'd1: begin cos_q15 <= -yq; sin_q15 <= xq;  end
        2'd2: begin cos_q15 <= -xq; sin_q15 <= -yq; end
        default: begin cos_q15 <= yq; sin_q15 <= -xq; end
      endcase
    end
  end

endmodule

/* hw/rtl/obb_separation_margin.sv */
// Separation margin of two oriented boxes by the separating axis test.
// Usage: each input request carries two boxes (center, heading, half length,
// half width). The block returns one signed margin per request, in the same
// length unit: positive means the boxes are separated, otherwise they overlap.
// Both channels are valid/stall; a request moves when valid is high and stall
// is low. The block holds no state between requests.
// The pipeline has sixteen register stages: one setup stage, eight CORDIC
// stages of two iterations each, a quadrant stage, then product, absolute
// value, support product, gap, maximum and rounding. Throughput is one request
// per cycle while out_stall is low; every stage has its own valid bit.
// When the receiver stalls, the output holds and upstream stages keep filling
// empty slots; in_stall rises only once every stage is full.
// Reset clears all valid bits; no result is pending after reset.
module obb_separation_margin (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_a_center_x,
  input  logic signed [23:0] in_a_center_y,
  input  logic [15:0]        in_a_heading,
  input  logic [15:0]        in_a_half_len,
  input  logic [15:0]        in_a_half_wid,
  input  logic signed [23:0] in_b_center_x,
  input  logic signed [23:0] in_b_center_y,
  input  logic [15:0]        in_b_heading,
  input  logic [15:0]        in_b_half_len,
  input  logic [15:0]        in_b_half_wid,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [27:0] out_gap_margin
);

  localparam int N = obbsm_pkg::NSTG;

  logic [N-1:0] v_r, en;

  always_comb begin
    en[N-1] = !v_r[N-1] || !out_stall;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[N-1];

  // Geometry rides alongside the CORDIC until the support products.
  obbsm_pkg::geo_t geo_r [obbsm_pkg::ST_SUP];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      geo_r[0].dx  <= 25'(in_b_center_x) - 25'(in_a_center_x);
      geo_r[0].dy  <= 25'(in_b_center_y) - 25'(in_a_center_y);
      geo_r[0].ahl <= in_a_half_len;
      geo_r[0].ahw <= in_a_half_wid;
      geo_r[0].bhl <= in_b_half_len;
      geo_r[0].bhw <= in_b_half_wid;
    end
    for (int i = 1; i < obbsm_pkg::ST_SUP; i++) begin
      if (en[i]) geo_r[i] <= geo_r[i-1];
    end
  end

  logic signed [15:0] ac, as, bc, bs;

  obbsm_sincos u_sc_a (
    .clk     (clk),
    .en      (en[obbsm_pkg::SC_STG-1:0]),
    .heading (in_a_heading),
    .cos_q15 (ac),
    .sin_q15 (as)
  );

  obbsm_sincos u_sc_b (
    .clk     (clk),
    .en      (en[obbsm_pkg::SC_STG-1:0]),
    .heading (in_b_heading),
    .cos_q15 (bc),
    .sin_q15 (bs)
  );

  // Axes: a.u, a.v, b.u, b.v.
  logic signed [15:0] ax [4];
  logic signed [15:0] ay [4];
  logic signed [15:0] bxc [2];
  logic signed [15:0] bxs [2];

  always_comb begin
    ax[0] = ac;  ay[0] = as;
    ax[1] = -as; ay[1] = ac;
    ax[2] = bc;  ay[2] = bs;
    ax[3] = -bs; ay[3] = bc;
    bxc[0] = ac; bxs[0] = as;
    bxc[1] = bc; bxs[1] = bs;
  end

  // Products: per axis and box, c*ax, s*ay, c*ay, s*ax.
  logic signed [31:0] m_r  [4][2][4];
  logic signed [40:0] px_r [4];
  logic signed [40:0] py_r [4];

  always_ff @(posedge clk) begin
    if (en[obbsm_pkg::ST_PROD]) begin
      for (int k = 0; k < 4; k++) begin
        px_r[k] <= 41'(geo_r[obbsm_pkg::ST_QUAD].dx) * 41'(ax[k]);
        py_r[k] <= 41'(geo_r[obbsm_pkg::ST_QUAD].dy) * 41'(ay[k]);
        for (int j = 0; j < 2; j++) begin
          m_r[k][j][0] <= 32'(bxc[j]) * 32'(ax[k]);
          m_r[k][j][1] <= 32'(bxs[j]) * 32'(ay[k]);
          m_r[k][j][2] <= 32'(bxc[j]) * 32'(ay[k]);
          m_r[k][j][3] <= 32'(bxs[j]) * 32'(ax[k]);
        end
      end
    end
  end

  logic [31:0] pa_r   [4][2];
  logic [31:0] qa_r   [4][2];
  logic [40:0] proj_r [4];

  always_ff @(posedge clk) begin
    if (en[obbsm_pkg::ST_ABS]) begin
      for (int k = 0; k < 4; k++) begin
        logic signed [41:0] pj;
        pj = 42'(px_r[k]) + 42'(py_r[k]);
        proj_r[k] <= pj[41] ? 41'(-pj) : 41'(pj);
        for (int j = 0; j < 2; j++) begin
          logic signed [32:0] sp, sq;
          sp = 33'(m_r[k][j][0]) + 33'(m_r[k][j][1]);
          sq = 33'(m_r[k][j][2]) - 33'(m_r[k][j][3]);
          pa_r[k][j] <= sp[32] ? 32'(-sp) : 32'(sp);
          qa_r[k][j] <= sq[32] ? 32'(-sq) : 32'(sq);
        end
      end
    end
  end

  logic [47:0] sup_r   [4][4];
  logic [40:0] proj2_r [4];

  always_ff @(posedge clk) begin
    if (en[obbsm_pkg::ST_SUP]) begin
      for (int k = 0; k < 4; k++) begin
        proj2_r[k]  <= proj_r[k];
        sup_r[k][0] <= 48'(geo_r[obbsm_pkg::ST_ABS].ahl) * 48'(pa_r[k][0]);
        sup_r[k][1] <= 48'(geo_r[obbsm_pkg::ST_ABS].ahw) * 48'(qa_r[k][0]);
        sup_r[k][2] <= 48'(geo_r[obbsm_pkg::ST_ABS].bhl) * 48'(pa_r[k][1]);
        sup_r[k][3] <= 48'(geo_r[obbsm_pkg::ST_ABS].bhw) * 48'(qa_r[k][1]);
      end
    end
  end

  logic signed [obbsm_pkg::GAP_W-1:0] gap_r [4];

  always_ff @(posedge clk) begin
    if (en[obbsm_pkg::ST_GAP]) begin
      for (int k = 0; k < 4; k++) begin
        gap_r[k] <= signed'((obbsm_pkg::GAP_W'(proj2_r[k]) << 15)
                    - obbsm_pkg::GAP_W'(sup_r[k][0]) - obbsm_pkg::GAP_W'(sup_r[k][1])
                    - obbsm_pkg::GAP_W'(sup_r[k][2]) - obbsm_pkg::GAP_W'(sup_r[k][3]));
      end
    end
  end

  logic signed [obbsm_pkg::GAP_W-1:0] m01, m23, best_r;

  assign m01 = (gap_r[1] > gap_r[0]) ? gap_r[1] : gap_r[0];
  assign m23 = (gap_r[3] > gap_r[2]) ? gap_r[3] : gap_r[2];

  always_ff @(posedge clk) begin
    if (en[obbsm_pkg::ST_MAX]) best_r <= (m23 > m01) ? m23 : m01;
  end

  logic signed [obbsm_pkg::GAP_W-1:0] rnd;
  assign rnd = (best_r + (obbsm_pkg::GAP_W'(1) << 29)) >>> 30;

  always_ff @(posedge clk) begin
    if (en[obbsm_pkg::ST_OUT]) begin
      if (rnd > obbsm_pkg::GAP_W'(134217727)) begin
        out_gap_margin <= 28'sh7FF_FFFF;
      end else if (rnd < -obbsm_pkg::GAP_W'(134217728)) begin
        out_gap_margin <= 28'sh800_0000;
      end else begin
        out_gap_margin <= rnd[27:0];
      end
    end
  end

endmodule

/* hw/rtl/obbsm_checker.sv */
// Port-level checker of the separation margin block and its bind.
`include "obb_separation_margin_defines.svh"

module obbsm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [27:0] out_gap_margin
);

  `OBBSM_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped under stall")
  `OBBSM_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_gap_margin), "stalled result changed")
  `OBBSM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result pending after reset")
  `OBBSM_ASSERT(a_no_idle_stall, clk, rst_n, !out_valid |-> !in_stall, "input stalled while output empty")

endmodule

bind obb_separation_margin obbsm_checker u_obbsm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_gap_margin (out_gap_margin)
);

/* verif/obb_separation_margin_test.sv */
// Self-checking testbench of the oriented box separation margin block.
module obb_separation_margin_test;

  typedef struct {
    logic signed [23:0] ax, ay, bx, by;
    logic [15:0] ah, al, aw, bh, bl, bw;
  } box_pair_t;

  // Sine and cosine of a heading in Q1.15, computed as the hardware does.
  function automatic void heading_sincos(input logic [15:0] hd,
                                         output longint c, output longint s);
    longint atan_tab[16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
    logic [31:0] ang, r;
    logic [1:0] q;
    longint x, y, z, nx;
    ang = {hd, 16'h0};
    q = 2'((ang + 32'h20000000) >> 30);
    r = ang - {q, 30'h0};
    z = longint'($signed(r));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
      end
      x = nx;
    end
    x = (x + 16384) >>> 15; y = (y + 16384) >>> 15;
    if (x > 32767) x = 32767; if (x < -32767) x = -32767;
    if (y > 32767) y = 32767; if (y < -32767) y = -32767;
    case (q)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [27:0] predict_margin(box_pair_t p);
    longint dx, dy, ac, as_, bc, bs, gx[4], gy[4], g, top, r;
    dx = longint'(p.bx) - longint'(p.ax);
    dy = longint'(p.by) - longint'(p.ay);
    heading_sincos(p.ah, ac, as_);
    heading_sincos(p.bh, bc, bs);
    gx = '{ac, -as_, bc, -bs};
    gy = '{as_, ac, bs, bc};
    top = 0;
    for (int k = 0; k < 4; k++) begin
      g = mag(dx * gx[k] + dy * gy[k]) * 32768
        - longint'(p.al) * mag(ac * gx[k] + as_ * gy[k])
        - longint'(p.aw) * mag(-as_ * gx[k] + ac * gy[k])
        - longint'(p.bl) * mag(bc * gx[k] + bs * gy[k])
        - longint'(p.bw) * mag(-bs * gx[k] + bc * gy[k]);
      if (k == 0 || g > top) top = g;
    end
    r = (top + (64'sd1 <<< 29)) >>> 30;
    if (r > 134217727) r = 134217727;
    if (r < -134217728) r = -134217728;
    return r[27:0];
  endfunction

  class margin_scoreboard;
    logic signed [27:0] pending_margins[$];
    int errors = 0;
    function void note_request(box_pair_t p);
      pending_margins.push_back(predict_margin(p));
    endfunction
    function void check_margin(logic signed [27:0] got);
      logic signed [27:0] want;
      if (pending_margins.size() == 0) begin
        $display("%0t: unexpected result gap_margin=%0d", $time, got);
        errors++;
        return;
      end
      want = pending_margins.pop_front();
      if (got !== want) begin
        $display("%0t: gap_margin mismatch expected=%0d actual=%0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  box_pair_t drv;
  logic signed [27:0] out_gap_margin;
  margin_scoreboard sb;
  longint cycle_count = 0;
  bit quiet_phase = 0;
  bit hold_off = 0;
  bit sending_done = 0;

  obb_separation_margin DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_a_center_x(drv.ax), .in_a_center_y(drv.ay), .in_a_heading(drv.ah),
    .in_a_half_len(drv.al), .in_a_half_wid(drv.aw),
    .in_b_center_x(drv.bx), .in_b_center_y(drv.by), .in_b_heading(drv.bh),
    .in_b_half_len(drv.bl), .in_b_half_wid(drv.bw),
    .out_valid(out_valid), .out_stall(out_stall), .out_gap_margin(out_gap_margin));

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("obb_separation_margin_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_margin(out_gap_margin);

  // Receiver: random stalls, or a long hold-off while the sender keeps going.
  always @(negedge clk)
    out_stall <= hold_off || (!quiet_phase && $urandom_range(99) < 6);

  initial begin
    wait (rst_n === 1'b1);
    repeat (300) @(negedge clk);
    hold_off = 1;
    repeat (80) @(negedge clk);
    hold_off = 0;
  end

  function automatic logic [23:0] rand_pos(int mode);
    case (mode)
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($signed($urandom_range(8000)) - 4000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic box_pair_t random_pair();
    box_pair_t p;
    int m;
    m = $urandom_range(9);
    p.ax = (m < 7) ? rand_pos(2) : rand_pos($urandom_range(3));
    p.ay = (m < 7) ? rand_pos(2) : rand_pos($urandom_range(3));
    p.bx = (m < 7) ? p.ax + rand_pos(2) : rand_pos($urandom_range(3));
    p.by = (m < 7) ? p.ay + rand_pos(2) : rand_pos($urandom_range(3));
    p.ah = 16'($urandom); p.bh = 16'($urandom);
    p.al = (m < 7) ? 16'($urandom_range(3000)) : 16'($urandom);
    p.aw = (m < 7) ? 16'($urandom_range(3000)) : 16'($urandom);
    p.bl = (m < 7) ? 16'($urandom_range(3000)) : 16'($urandom);
    p.bw = (m < 7) ? 16'($urandom_range(3000)) : 16'($urandom);
    return p;
  endfunction

  task automatic send_request(box_pair_t p);
    while (!quiet_phase && $urandom_range(99) < 6) begin
      in_valid <= 0;
      @(negedge clk);
    end
    drv <= p;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(p);
    @(negedge clk);
  endtask

  initial begin
    box_pair_t p;
    logic [15:0] dir_heads[8] = '{16'h0000, 16'h2000, 16'h4000, 16'h6000,
                                   16'h8000, 16'hA000, 16'hC000, 16'hFFFF};
    sb = new();
    rst_n = 0; in_valid = 0;
    drv = '{default: '0};
    repeat (6) @(negedge clk);
    rst_n = 1;
    // Directed: headings at octant boundaries and just below a full turn, extreme sizes and positions.
    for (int i = 0; i < 8; i++) begin
      p = '{ax: 0, ay: 0, bx: 24'sd1000, by: -24'sd700, ah: dir_heads[i],
            bh: dir_heads[7 - i], al: 300, aw: 100, bl: 200, bw: 50};
      send_request(p);
    end
    p = '{ax: 24'h800000, ay: 24'h800000, bx: 24'h7FFFFF, by: 24'h7FFFFF,
          ah: 16'h1234, bh: 16'h0, al: 0, aw: 0, bl: 0, bw: 0};
    send_request(p);
    p = '{ax: 24'h7FFFFF, ay: 24'h800000, bx: 24'h800000, by: 24'h7FFFFF,
          ah: 16'h0, bh: 16'h4000, al: 16'hFFFF, aw: 16'hFFFF, bl: 16'hFFFF, bw: 16'hFFFF};
    send_request(p);
    p = '{ax: 5, ay: 5, bx: 5, by: 5, ah: 16'hFFFF, bh: 16'h8001,
          al: 16'hFFFF, aw: 16'hFFFF, bl: 16'hFFFF, bw: 16'hFFFF};
    send_request(p);
    p = '{ax: 0, ay: 0, bx: 0, by: 0, ah: 0, bh: 0, al: 0, aw: 0, bl: 0, bw: 0};
    send_request(p);
    for (int n = 0; n < 1650; n++) begin
      quiet_phase = (n >= 600 && n < 900);
      send_request(random_pair());
    end
    in_valid <= 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (sb.pending_margins.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("obb_separation_margin_test: PASS");
    else
      $display("obb_separation_margin_test: FAIL");
    $finish;
  end

endmodule
